// ----- design/fvfp_pkg.sv -----
// Shared types, constants and CRC helpers for the FLAC verbatim frame packer.
// No dependencies; compiled first.
`default_nettype none

package fvfp_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int LEN_W    = 9;
    localparam int CFG_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 13;
    localparam int SNUM_W   = 36;
    localparam int CODE_W   = 3;
    localparam int NUMK_W   = 3;

    // Defaults for the top-level parameters
    localparam int MAX_BLOCK_DEF    = 256;
    localparam int MAX_CHANNELS_DEF = 8;

    // Descriptor queue depth between front and back
    localparam int Q_DEPTH = 4;

    // Stream constants
    localparam logic [BYTE_W-1:0] SYNC_B0        = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_B1        = 8'hF9;
    localparam logic [BYTE_W-1:0] SYNC_B2        = 8'h60;
    localparam logic [3:0]        SIZE_CODE      = 4'h6;
    localparam logic [BYTE_W-1:0] SUBFR_VERBATIM = 8'h02;
    localparam logic [BYTE_W-1:0] CONT_MARK      = 8'h80;
    localparam logic [7:0]        CRC8_POLY      = 8'h07;
    localparam logic [15:0]       CRC16_POLY     = 16'h8005;
    localparam logic [CFG_W-1:0]  CHAN_CNT_RST   = 4'd2;

    // One classified request, handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first_of_frame;
        logic                first_of_chan;
        logic                last_of_frame;
        logic [CODE_W-1:0]   chan_m1;
        logic [BYTE_W-1:0]   len_m1;
        logic [SNUM_W-1:0]   snum;
        logic [NUMK_W-1:0]   numk;
    } t_desc;

    // Byte slots of the serialiser, one-hot
    typedef enum logic [12:0] {
        ST_SYNC0 = 13'h0001,
        ST_SYNC1 = 13'h0002,
        ST_SYNC2 = 13'h0004,
        ST_CHAN  = 13'h0008,
        ST_NUM   = 13'h0010,
        ST_LEN   = 13'h0020,
        ST_HCRC  = 13'h0040,
        ST_SUBF  = 13'h0080,
        ST_S2    = 13'h0100,
        ST_S1    = 13'h0200,
        ST_S0    = 13'h0400,
        ST_C16H  = 13'h0800,
        ST_C16L  = 13'h1000
    } t_step;

    // CRC-8, poly 0x07, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ((r << 1) ^ CRC8_POLY) : (r << 1);
        end
        return r;
    endfunction

    // CRC-16, poly 0x8005, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ CRC16_POLY) : (r << 1);
        end
        return r;
    endfunction

    // Number of continuation bytes for the coded sample number
    function automatic logic [NUMK_W-1:0] num_class(input logic [SNUM_W-1:0] v);
        logic [NUMK_W-1:0] k;
        if (v < 36'h80)               k = 3'd0;
        else if (v < 36'h800)         k = 3'd1;
        else if (v < 36'h10000)       k = 3'd2;
        else if (v < 36'h200000)      k = 3'd3;
        else if (v < 36'h4000000)     k = 3'd4;
        else if (v < 36'h80000000)    k = 3'd5;
        else                          k = 3'd6;
        return k;
    endfunction

    // Lead byte marker for a given continuation count
    function automatic logic [BYTE_W-1:0] num_prefix(input logic [NUMK_W-1:0] k);
        logic [BYTE_W-1:0] p;
        case (k)
            3'd0:    p = 8'h00;
            3'd1:    p = 8'hC0;
            3'd2:    p = 8'hE0;
            3'd3:    p = 8'hF0;
            3'd4:    p = 8'hF8;
            3'd5:    p = 8'hFC;
            3'd6:    p = 8'hFE;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    // Eight bits of v starting at bit 6*j
    function automatic logic [BYTE_W-1:0] num_slice(input logic [SNUM_W-1:0] v,
                                                    input logic [NUMK_W-1:0] j);
        logic [47:0]       ext;
        logic [BYTE_W-1:0] s;
        ext = {12'h000, v};
        case (j)
            3'd0:    s = ext[7:0];
            3'd1:    s = ext[13:6];
            3'd2:    s = ext[19:12];
            3'd3:    s = ext[25:18];
            3'd4:    s = ext[31:24];
            3'd5:    s = ext[37:30];
            3'd6:    s = ext[43:36];
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- design/fvfp_if.sv -----
// Valid/ready channel interfaces for the frame packer: sample input and byte output.
// Depends on fvfp_pkg for field widths.
`default_nettype none

interface fvfp_in_if import fvfp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic        [LEN_W-1:0]    block_length;

    modport source (output valid, output sample_value, output block_length, input ready);
    modport sink   (input valid, input sample_value, input block_length, output ready);
endinterface

interface fvfp_out_if import fvfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              last_of_frame;
    logic [SIZE_W-1:0] frame_size;

    modport source (output valid, output out_byte, output last_of_run,
                    output last_of_frame, output frame_size, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input last_of_frame, input frame_size, output ready);
endinterface

`default_nettype wire

// ----- design/fvfp_front.sv -----
// Front end: accepts sample requests, tracks frame position and sample number,
// and issues one descriptor per request. Depends on fvfp_pkg and fvfp_in_if.
`default_nettype none

module fvfp_front import fvfp_pkg::*; #(
    parameter int MAX_BLOCK    = MAX_BLOCK_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_chan_cnt,
    fvfp_in_if.sink               i_in,
    input  wire logic             i_full,
    output logic                  o_push,
    output t_desc                 o_desc
);

    localparam int POS_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [SNUM_W-1:0] r_snum, n_snum;

    logic [CFG_W-1:0] chans;
    logic [CFG_W-1:0] ch_inc;
    logic [LEN_W-1:0] len_in;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] pos_inc;
    logic             frame_start;
    logic             blk_end;
    logic             frm_end;

    // Take a request whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Clamp channel count and block length into range
    always_comb begin
        if (i_chan_cnt == '0) begin
            chans = CFG_W'(1);
        end else if (i_chan_cnt > CFG_W'(MAX_CHANNELS)) begin
            chans = CFG_W'(MAX_CHANNELS);
        end else begin
            chans = i_chan_cnt;
        end
        if (i_in.block_length == '0) begin
            len_in = LEN_W'(1);
        end else if (i_in.block_length > LEN_W'(MAX_BLOCK)) begin
            len_in = LEN_W'(MAX_BLOCK);
        end else begin
            len_in = i_in.block_length;
        end
    end

    // Position bookkeeping
    assign frame_start = (r_ch == '0) && (r_pos == '0);
    assign eff_len     = frame_start ? len_in : r_len;
    assign pos_inc     = LEN_W'(r_pos) + LEN_W'(1);
    assign blk_end     = pos_inc >= eff_len;
    assign ch_inc      = CFG_W'(r_ch) + CFG_W'(1);
    assign frm_end     = blk_end && (ch_inc >= chans);

    always_comb begin
        n_len  = eff_len;
        n_pos  = blk_end ? '0 : pos_inc[POS_W-1:0];
        n_ch   = r_ch;
        n_snum = r_snum;
        if (blk_end) begin
            n_ch = frm_end ? '0 : ch_inc[CH_W-1:0];
        end
        if (frm_end) begin
            n_snum = r_snum + SNUM_W'(eff_len);
        end
    end

    // Descriptor for the back end
    always_comb begin
        o_desc.sample         = i_in.sample_value;
        o_desc.first_of_frame = frame_start;
        o_desc.first_of_chan  = (r_pos == '0);
        o_desc.last_of_frame  = frm_end;
        o_desc.chan_m1        = CODE_W'(chans - CFG_W'(1));
        o_desc.len_m1         = BYTE_W'(eff_len - LEN_W'(1));
        o_desc.snum           = r_snum;
        o_desc.numk           = num_class(r_snum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_ch   <= '0;
            r_len  <= '0;
            r_snum <= '0;
        end else if (o_push) begin
            r_pos  <= n_pos;
            r_ch   <= n_ch;
            r_len  <= n_len;
            r_snum <= n_snum;
        end
    end

endmodule

`default_nettype wire

// ----- design/fvfp_queue.sv -----
// Short descriptor FIFO decoupling the front end from the byte serialiser.
// Depends on fvfp_pkg for t_desc and Q_DEPTH.
`default_nettype none

module fvfp_queue import fvfp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_data,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_desc      o_head
);

    localparam int QA_W = $clog2(Q_DEPTH);

    t_desc            r_mem [Q_DEPTH];
    logic [QA_W-1:0]  r_wr, r_rd;
    logic [QA_W:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QA_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (QA_W+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (QA_W+1)'(1);
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QA_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QA_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("descriptor queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("descriptor queue read while empty");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QA_W+1)'(Q_DEPTH))
        else $error("descriptor queue count out of range");

endmodule

`default_nettype wire

// ----- design/fvfp_back.sv -----
// Back end: serialises descriptors into frame bytes, one byte per cycle unless the
// output stalls; running CRC-8/CRC-16 and byte count. Depends on fvfp_pkg, fvfp_out_if.
`default_nettype none

module fvfp_back import fvfp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_desc i_head,
    input  wire logic  i_head_valid,
    output logic       o_pop,
    fvfp_out_if.source o_out
);

    t_step             r_step, n_step, cur;
    logic              r_mid;
    logic [NUMK_W-1:0] r_idx, n_idx;
    logic [7:0]        r_crc8, n_crc8;
    logic [15:0]       r_crc16, n_crc16;
    logic [SIZE_W-1:0] r_count, n_count;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_run;
    logic              r_out_frame;
    logic [SIZE_W-1:0] r_out_size;

    logic [BYTE_W-1:0] b;
    logic              hdr;
    logic              body;
    logic              last_run;
    logic              last_frame;
    logic              go;

    // Slot of the byte going out this cycle
    always_comb begin
        if (r_mid) begin
            cur = r_step;
        end else if (i_head.first_of_frame) begin
            cur = ST_SYNC0;
        end else if (i_head.first_of_chan) begin
            cur = ST_SUBF;
        end else begin
            cur = ST_S2;
        end
    end

    assign go = i_head_valid && (!r_out_valid || o_out.ready);

    // Byte selection and slot sequencing
    always_comb begin
        b          = '0;
        n_step     = ST_SYNC0;
        n_idx      = r_idx;
        hdr        = 1'b0;
        body       = 1'b1;
        last_run   = 1'b0;
        last_frame = 1'b0;
        case (cur)
            ST_SYNC0: begin
                b = SYNC_B0; hdr = 1'b1; n_step = ST_SYNC1;
            end
            ST_SYNC1: begin
                b = SYNC_B1; hdr = 1'b1; n_step = ST_SYNC2;
            end
            ST_SYNC2: begin
                b = SYNC_B2; hdr = 1'b1; n_step = ST_CHAN;
            end
            ST_CHAN: begin
                b      = {1'b0, i_head.chan_m1, SIZE_CODE};
                hdr    = 1'b1;
                n_step = ST_NUM;
                n_idx  = i_head.numk;
            end
            ST_NUM: begin
                hdr = 1'b1;
                if (r_idx == i_head.numk) begin
                    b = num_prefix(i_head.numk) | num_slice(i_head.snum, r_idx);
                end else begin
                    b = CONT_MARK | (num_slice(i_head.snum, r_idx) & 8'h3F);
                end
                n_step = (r_idx == '0) ? ST_LEN : ST_NUM;
                n_idx  = r_idx - NUMK_W'(1);
            end
            ST_LEN: begin
                b = i_head.len_m1; hdr = 1'b1; n_step = ST_HCRC;
            end
            ST_HCRC: begin
                b = r_crc8; n_step = ST_SUBF;
            end
            ST_SUBF: begin
                b = SUBFR_VERBATIM; n_step = ST_S2;
            end
            ST_S2: begin
                b = i_head.sample[23:16]; n_step = ST_S1;
            end
            ST_S1: begin
                b = i_head.sample[15:8]; n_step = ST_S0;
            end
            ST_S0: begin
                b        = i_head.sample[7:0];
                n_step   = ST_C16H;
                last_run = !i_head.last_of_frame;
            end
            ST_C16H: begin
                b = r_crc16[15:8]; body = 1'b0; n_step = ST_C16L;
            end
            ST_C16L: begin
                b          = r_crc16[7:0];
                body       = 1'b0;
                last_run   = 1'b1;
                last_frame = 1'b1;
            end
            default: begin
                b = '0;
            end
        endcase
    end

    // Running checks and byte count; a frame always opens on the first sync byte
    always_comb begin
        n_crc8  = r_crc8;
        n_crc16 = r_crc16;
        if (hdr) begin
            n_crc8 = crc8_byte((cur == ST_SYNC0) ? 8'h00 : r_crc8, b);
        end
        if (body) begin
            n_crc16 = crc16_byte((cur == ST_SYNC0) ? 16'h0000 : r_crc16, b);
        end
        n_count = (cur == ST_SYNC0) ? SIZE_W'(1) : r_count + SIZE_W'(1);
    end

    assign o_pop = go && last_run;

    // Serialiser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_SYNC0;
            r_mid   <= 1'b0;
            r_idx   <= '0;
            r_crc8  <= '0;
            r_crc16 <= '0;
            r_count <= '0;
        end else if (go) begin
            r_step  <= n_step;
            r_mid   <= !last_run;
            r_idx   <= n_idx;
            r_crc8  <= n_crc8;
            r_crc16 <= n_crc16;
            r_count <= n_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte  <= b;
            r_out_run   <= last_run;
            r_out_frame <= last_frame;
            r_out_size  <= last_frame ? n_count : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.last_of_run   = r_out_run;
    assign o_out.last_of_frame = r_out_frame;
    assign o_out.frame_size    = r_out_size;

    a_mid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> i_head_valid)
        else $error("request in progress lost its descriptor");

    a_frame_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_frame) |-> r_out_run)
        else $error("frame end without end of request");

    a_size_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_frame) |-> (r_out_size == '0))
        else $error("frame size shown before frame end");

endmodule

`default_nettype wire

// ----- design/flac_verbatim_frame_packer.sv -----
// FLAC verbatim frame packer top level: channel count register, front end,
// descriptor queue and byte serialiser. Depends on fvfp_pkg and fvfp_if.
// Throughput: one byte per cycle while a descriptor waits and the output is free;
// a sample takes 3 bytes, 4 on a channel's first sample, 11+k on a frame's first
// (k = continuation bytes of the sample number), +2 at frame end for the CRC-16;
// the serialiser's single byte lane sets this. A request's first byte passes the
// descriptor queue and the output register. Reset (synchronous, active low) clears
// position, sample number, queue and output; channel count returns to 2.
`default_nettype none

module flac_verbatim_frame_packer import fvfp_pkg::*; #(
    parameter int MAX_BLOCK    = MAX_BLOCK_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    fvfp_in_if.sink               i_in,
    fvfp_out_if.source            o_out
);

    logic [CFG_W-1:0] r_chan_cnt;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    t_desc            desc;
    t_desc            head;

    // Channel count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= CHAN_CNT_RST;
        end else if (i_cfg_we) begin
            r_chan_cnt <= i_cfg_wdata;
        end
    end

    fvfp_front #(
        .MAX_BLOCK    (MAX_BLOCK),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_chan_cnt (r_chan_cnt),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_desc     (desc)
    );

    fvfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    fvfp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (!empty),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// ----- bench/fvfp_frame_tracker_pkg.sv -----
`timescale 1ns / 100ps
// Frame tracker for the FLAC verbatim frame packer bench: predicts the byte stream
// from accepted sample requests and checks each output byte. Depends on fvfp_pkg.

package fvfp_frame_tracker_pkg;
    import fvfp_pkg::*;

    // One predicted output byte with its side-band flags
    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                run_end;
        bit                frame_end;
        logic [SIZE_W-1:0] size;
    } t_frame_byte;

    class flac_frame_tracker;
        // Register and encoder state
        logic [CFG_W-1:0]  chan_reg;
        logic [SNUM_W-1:0] sample_number;
        logic [7:0]        hdr_crc;
        logic [15:0]       body_crc;
        int                chan_idx;
        int                blk_pos;
        int                blk_len;
        logic [SIZE_W-1:0] byte_count;

        t_frame_byte       pending_bytes[$];
        int                fault_count;

        function new();
            chan_reg      = CHAN_CNT_RST;
            sample_number = '0;
            hdr_crc       = '0;
            body_crc      = '0;
            chan_idx      = 0;
            blk_pos       = 0;
            blk_len       = 0;
            byte_count    = '0;
            fault_count   = 0;
        endfunction

        function void set_channels(logic [CFG_W-1:0] v);
            chan_reg = v;
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        function bit at_frame_start();
            return (chan_idx == 0) && (blk_pos == 0);
        endfunction

        function int faults();
            return fault_count;
        endfunction

        // Bit-serial CRC updates, MSB of the data byte first
        function void crc_feed(logic [7:0] b, bit hdr, bit body);
            bit fb;
            for (int i = 7; i >= 0; i--) begin
                if (hdr) begin
                    fb      = hdr_crc[7] ^ b[i];
                    hdr_crc = {hdr_crc[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
                end
                if (body) begin
                    fb       = body_crc[15] ^ b[i];
                    body_crc = {body_crc[14:0], 1'b0} ^ (fb ? 16'h8005 : 16'h0000);
                end
            end
        endfunction

        function void emit(logic [7:0] b, bit hdr, bit body);
            t_frame_byte e;
            e.data      = b;
            e.run_end   = 1'b0;
            e.frame_end = 1'b0;
            e.size      = '0;
            pending_bytes.insert(pending_bytes.size(), e);
            crc_feed(b, hdr, body);
            byte_count = byte_count + 1'b1;
        endfunction

        // Sets flags on the newest predicted byte
        function void flag_tail(bit frame_end, logic [SIZE_W-1:0] size);
            t_frame_byte e;
            int          tail_idx;
            tail_idx = pending_bytes.size() - 1;
            e = pending_bytes[tail_idx];
            e.run_end = 1'b1;
            if (frame_end) begin
                e.frame_end = 1'b1;
                e.size      = size;
            end
            pending_bytes[tail_idx] = e;
        endfunction

        // UTF-8 style coding of the running sample number
        function void emit_sample_number(logic [SNUM_W-1:0] v);
            int          nbits;
            int          k;
            logic [7:0]  lead;
            nbits = 0;
            for (int i = 0; i < SNUM_W; i++) begin
                if (v[i]) nbits = i + 1;
            end
            k = (nbits <= 7) ? 0 : (nbits - 2) / 5;
            lead = (k == 0) ? 8'h00 : ~(8'hFF >> (k + 1));
            emit(lead | 8'(v >> (6 * k)), 1'b1, 1'b1);
            for (int j = k - 1; j >= 0; j--) begin
                emit({2'b10, 6'(v >> (6 * j))}, 1'b1, 1'b1);
            end
        endfunction

        // Predicts every byte caused by one accepted request
        function void predict_sample(logic [SAMPLE_W-1:0] s, logic [LEN_W-1:0] len);
            int chans;
            int l;
            int nxt;
            bit frame_done;
            chans = int'(chan_reg);
            if (chans < 1) chans = 1;
            if (chans > 8) chans = 8;
            frame_done = 1'b0;

            // Frame header on the first request of a frame
            if (at_frame_start()) begin
                l = int'(len);
                if (l < 1) l = 1;
                if (l > 256) l = 256;
                blk_len    = l;
                hdr_crc    = '0;
                body_crc   = '0;
                byte_count = '0;
                emit(SYNC_B0, 1'b1, 1'b1);
                emit(SYNC_B1, 1'b1, 1'b1);
                emit(SYNC_B2, 1'b1, 1'b1);
                emit({4'(chans - 1), SIZE_CODE}, 1'b1, 1'b1);
                emit_sample_number(sample_number);
                emit(8'(l - 1), 1'b1, 1'b1);
                emit(hdr_crc, 1'b0, 1'b1);
            end

            // Subframe marker, then the sample big-endian
            if (blk_pos == 0) emit(SUBFR_VERBATIM, 1'b0, 1'b1);
            emit(s[23:16], 1'b0, 1'b1);
            emit(s[15:8], 1'b0, 1'b1);
            emit(s[7:0], 1'b0, 1'b1);

            // Advance position; close the frame after the last channel
            blk_pos++;
            if (blk_pos >= blk_len) begin
                blk_pos = 0;
                nxt = chan_idx + 1;
                if (nxt >= chans) begin
                    emit(body_crc[15:8], 1'b0, 1'b0);
                    emit(body_crc[7:0], 1'b0, 1'b0);
                    frame_done    = 1'b1;
                    sample_number = sample_number + SNUM_W'(blk_len);
                    nxt = 0;
                end
                chan_idx = nxt & 7;
            end
            blk_pos = blk_pos & 8'hFF;
            flag_tail(frame_done, byte_count);
        endfunction

        // Compares one accepted output byte with the oldest prediction
        function void check_byte(logic [7:0] b, logic run_end, logic frame_end,
                                 logic [SIZE_W-1:0] size);
            t_frame_byte e;
            if (pending_bytes.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected byte %02h (run_end %0b frame_end %0b size %0d)",
                             b, run_end, frame_end, size);
                return;
            end
            e = pending_bytes.pop_front();
            if (b !== e.data || run_end !== e.run_end || frame_end !== e.frame_end ||
                size !== e.size) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("byte mismatch: exp %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d",
                             e.data, e.run_end, e.frame_end, e.size,
                             b, run_end, frame_end, size);
            end
        endfunction
    endclass

endpackage

// ----- bench/flac_verbatim_frame_packer_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for flac_verbatim_frame_packer: directed and random sample requests,
// random idling on both channels. Depends on fvfp_pkg, fvfp_if, fvfp_frame_tracker_pkg.

module flac_verbatim_frame_packer_tb;
    import fvfp_pkg::*;
    import fvfp_frame_tracker_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    fvfp_in_if  smp_if ();
    fvfp_out_if byte_if ();

    flac_verbatim_frame_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (smp_if.sink),
        .o_out       (byte_if.source)
    );

    flac_frame_tracker tracker;

    // Idling controls shared between the driver and the receiver
    bit tx_quiet;
    bit rx_quiet;
    int rx_hold_cycles;

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard limit on run time
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one request after a random gap and waits for acceptance
    task automatic send_request(logic [SAMPLE_W-1:0] s, logic [LEN_W-1:0] len);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.sample_value <= s;
        smp_if.block_length <= len;
        do @(posedge i_clk); while (!(smp_if.valid && smp_if.ready));
        tracker.predict_sample(s, len);
    endtask

    // Stops offering and waits until every predicted byte has come out
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_channels(logic [CFG_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tracker.set_channels(v);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Block length for a frame's first request: mostly short
    function automatic logic [LEN_W-1:0] pick_first_len();
        case ($urandom_range(0, 11))
            0:       return 9'd0;
            1:       return LEN_W'($urandom_range(7, 16));
            default: return LEN_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_channels();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return CFG_W'($urandom_range(9, 15));
            2:       return 4'd8;
            3:       return 4'd1;
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Receiver: random stalls, an occasional long hold-off, checks every byte
    initial begin
        int stall;
        byte_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                byte_if.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                byte_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            byte_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(byte_if.valid && byte_if.ready));
            tracker.check_byte(byte_if.out_byte, byte_if.last_of_run,
                               byte_if.last_of_frame, byte_if.frame_size);
        end
    end

    // Stimulus
    initial begin
        logic [SAMPLE_W-1:0] corner [8];
        logic [LEN_W-1:0]    len;
        int                  rand_items;
        int                  frames;
        int                  done;
        bit                  cut;

        corner = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h7FFFFF,
                   24'h800000, 24'h555555, 24'hAAAAAA, 24'h123456};
        tracker        = new();
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        rx_hold_cycles = 0;
        smp_if.valid        = 1'b0;
        smp_if.sample_value = '0;
        smp_if.block_length = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        i_rst_n   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset channel count of two, length two
        for (int i = 0; i < 4; i++) send_request(corner[i + 4], (i == 0) ? 9'd2 : 9'h1FF);

        // Single channel, block length zero taken as one
        write_channels(4'd1);
        send_request(24'h7FFFFF, 9'd0);
        // Channel count zero taken as one
        write_channels(4'd0);
        send_request(24'h800000, 9'd1);
        // Count above eight taken as eight, one sample per channel
        write_channels(4'd15);
        for (int i = 0; i < 8; i++) send_request(corner[i], (i == 0) ? 9'd1 : 9'h100);

        // Count lowered mid-frame to the current channel
        write_channels(4'd3);
        send_request(24'h010203, 9'd1);
        write_channels(4'd1);
        send_request(24'hFEDCBA, 9'd1);
        // Count lowered mid-frame below the current channel
        write_channels(4'd4);
        for (int i = 0; i < 3; i++) send_request(corner[i + 3], 9'd1);
        write_channels(4'd2);
        send_request(24'h0F0F0F, 9'd1);

        // Receiver holds off while the sender keeps offering
        write_channels(4'd8);
        tx_quiet       = 1'b1;
        rx_hold_cycles = 400;
        send_request(pick_sample(), 9'd4);
        for (int i = 1; i < 32; i++) send_request(pick_sample(), LEN_W'($urandom));
        tx_quiet = 1'b0;

        // Random phases; some stop mid-frame so the next count change lands inside one
        rand_items = 0;
        while (rand_items < 95) begin
            write_channels(pick_channels());
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            frames   = $urandom_range(1, 3);
            cut      = ($urandom_range(0, 4) == 0);
            done     = 0;
            while (done < frames && rand_items < 95) begin
                len = tracker.at_frame_start() ? pick_first_len() : LEN_W'($urandom);
                send_request(pick_sample(), len);
                rand_items++;
                if (tracker.at_frame_start()) done++;
                else if (cut && $urandom_range(0, 5) == 0) break;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // Length above the maximum taken as the maximum; the frame is left open
        write_channels(4'd1);
        while (!tracker.at_frame_start()) send_request(pick_sample(), LEN_W'($urandom));
        send_request(pick_sample(), 9'h1FF);
        for (int i = 1; i < 8; i++) send_request(pick_sample(), LEN_W'($urandom));

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (tracker.faults() == 0 && tracker.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
